FILE: rtl/jtl_pkg.sv
// Shared types, character codes and token kinds for the JSON token lexer.
`timescale 1ns / 1ps

package jtl_pkg;

    // Default width of the internal byte position counter.
    localparam int POS_WIDTH_DEFAULT = 32;
    // Width of the positions that are reported on the output.
    localparam int OUT_POS_WIDTH = 32;
    // Depth of the token queue ahead of the output port.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    // Character codes used by the scanner.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_LOW_E   = 8'h65;
    localparam logic [7:0] CH_UP_E    = 8'h45;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;

    // Token kinds as they appear on the output.
    typedef enum logic [3:0] {
        KIND_LCURLY  = 4'd0,
        KIND_RCURLY  = 4'd1,
        KIND_LSQUARE = 4'd2,
        KIND_RSQUARE = 4'd3,
        KIND_COLON   = 4'd4,
        KIND_COMMA   = 4'd5,
        KIND_STRING  = 4'd6,
        KIND_INTEGER = 4'd7,
        KIND_FLOAT   = 4'd8,
        KIND_KEYWORD = 4'd9,
        KIND_ERROR   = 4'd10
    } kind_t;

    // Scanner modes, one-hot.
    typedef enum logic [11:0] {
        MODE_START      = 12'b0000_0000_0001,
        MODE_STRING     = 12'b0000_0000_0010,
        MODE_ZERO       = 12'b0000_0000_0100,
        MODE_SIGN       = 12'b0000_0000_1000,
        MODE_INT        = 12'b0000_0001_0000,
        MODE_FRAC       = 12'b0000_0010_0000,
        MODE_EXP_START  = 12'b0000_0100_0000,
        MODE_EXP_SIGN   = 12'b0000_1000_0000,
        MODE_EXP_DIGITS = 12'b0001_0000_0000,
        MODE_KEYWORD    = 12'b0010_0000_0000,
        MODE_AFTER      = 12'b0100_0000_0000,
        MODE_HALTED     = 12'b1000_0000_0000
    } mode_t;

    // One token as it leaves the block.
    typedef struct packed {
        kind_t                      kind;
        logic [OUT_POS_WIDTH-1:0]   first_pos;
        logic [OUT_POS_WIDTH-1:0]   final_pos;
        logic                       last_of_run;
    } token_t;

    // Tokens produced by one text byte, in order.
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } results_t;

endpackage

FILE: rtl/json_token_lexer_top.sv
// Top level of the JSON token lexer: input register, scanner and token queue.
//
//  Channel  | Direction | tdata                          | tuser      | tlast
//  ---------+-----------+--------------------------------+------------+------------
//  s_axis   | in        | [7:0] text_byte                | -          | end_of_text
//  m_axis   | out       | [31:0] first_pos, [63:32] final_pos | token_kind | last_of_run
//
// One text byte is taken per clock while the queue has room. A byte that causes
// two tokens writes both into the queue at once, while the output side delivers
// at most one token per clock. An accepted byte passes the input register, then
// the queue write, on its way to the output. The queue holds four tokens and the
// input stalls when fewer than two places are free. Reset clears the scanner
// state, the byte position and the queue.
`timescale 1ns / 1ps

module json_token_lexer_top #(
    parameter int POS_WIDTH = jtl_pkg::POS_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic        s_tlast,    // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] first_pos, [63:32] final_pos
    output logic [3:0]  m_tuser,    // [3:0] token_kind
    output logic        m_tlast     // last_of_run
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_eot_reg;
    logic              advance;
    logic              room;
    jtl_pkg::results_t results;
    jtl_pkg::token_t   out_token;

    // The held item moves on when the queue has room for its tokens.
    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    // Scanner.
    jtl_core #(
        .POS_WIDTH (POS_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .results     (results)
    );

    // Output token queue.
    jtl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (results),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_token (out_token)
    );

    assign m_tdata = {out_token.final_pos, out_token.first_pos};
    assign m_tuser = out_token.kind;
    assign m_tlast = out_token.last_of_run;

endmodule

FILE: rtl/jtl_core.sv
// Scanner state and per-byte token decision logic for the JSON token lexer.
`timescale 1ns / 1ps

module jtl_core #(
    parameter int POS_WIDTH = jtl_pkg::POS_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        text_byte,
    input  logic              end_of_text,
    output jtl_pkg::results_t results
);

    localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);

    jtl_pkg::mode_t          mode_reg, mode_next;
    logic                    frac_reg, frac_next;
    logic                    sq_reg, sq_next;
    logic                    esc_reg, esc_next;
    logic [POS_WIDTH-1:0]    begin_reg, begin_next;
    logic [POS_WIDTH-1:0]    pos_reg, pos_next;

    logic                    is_digit, is_alpha, is_lower, is_space, is_term, is_exp_mark;
    logic                    do_start, do_close, do_after;
    jtl_pkg::kind_t          close_kind;
    jtl_pkg::kind_t          punct_kind;
    logic                    is_punct;
    logic [7:0]              quote_char;
    jtl_pkg::results_t       res;

    // Reports a position in the output width, zero-extended or truncated.
    function automatic logic [jtl_pkg::OUT_POS_WIDTH-1:0] out_pos(logic [POS_WIDTH-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[jtl_pkg::OUT_POS_WIDTH-1:0];
    endfunction

    // Appends a token to the list for this byte; more than two are dropped.
    function automatic jtl_pkg::results_t add_tok(jtl_pkg::results_t r, jtl_pkg::kind_t k,
                                                  logic [POS_WIDTH-1:0] f,
                                                  logic [POS_WIDTH-1:0] l);
        jtl_pkg::token_t t;
        jtl_pkg::results_t o;
        t.kind        = k;
        t.first_pos   = out_pos(f);
        t.final_pos   = out_pos(l);
        t.last_of_run = 1'b0;
        o = r;
        if (r.count == 2'd0)
        begin
            o.tok0  = t;
            o.count = 2'd1;
        end
        else if (r.count == 2'd1)
        begin
            o.tok1  = t;
            o.count = 2'd2;
        end
        return o;
    endfunction

    // Character classes of the current byte.
    always_comb
    begin
        is_digit    = text_byte inside {[jtl_pkg::CH_ZERO:jtl_pkg::CH_NINE]};
        is_lower    = text_byte inside {[jtl_pkg::CH_LOW_A:jtl_pkg::CH_LOW_Z]};
        is_alpha    = is_lower || (text_byte inside {[jtl_pkg::CH_UP_A:jtl_pkg::CH_UP_Z]});
        is_space    = text_byte inside {jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB,
                                        jtl_pkg::CH_CR, jtl_pkg::CH_LF};
        is_exp_mark = text_byte inside {jtl_pkg::CH_LOW_E, jtl_pkg::CH_UP_E};
        is_term     = is_space || (text_byte inside {jtl_pkg::CH_RCURLY, jtl_pkg::CH_RSQUARE,
                                                     jtl_pkg::CH_COMMA, jtl_pkg::CH_COLON});
        quote_char  = sq_reg ? jtl_pkg::CH_SQUOTE : jtl_pkg::CH_DQUOTE;
    end

    // Single-byte punctuation tokens.
    always_comb
    begin
        is_punct   = 1'b1;
        punct_kind = jtl_pkg::KIND_ERROR;
        case (text_byte)
            jtl_pkg::CH_LCURLY:  punct_kind = jtl_pkg::KIND_LCURLY;
            jtl_pkg::CH_RCURLY:  punct_kind = jtl_pkg::KIND_RCURLY;
            jtl_pkg::CH_LSQUARE: punct_kind = jtl_pkg::KIND_LSQUARE;
            jtl_pkg::CH_RSQUARE: punct_kind = jtl_pkg::KIND_RSQUARE;
            jtl_pkg::CH_COLON:   punct_kind = jtl_pkg::KIND_COLON;
            jtl_pkg::CH_COMMA:   punct_kind = jtl_pkg::KIND_COMMA;
            default:             is_punct   = 1'b0;
        endcase
    end

    // Next state and the tokens caused by this byte.
    always_comb
    begin
        res        = '0;
        mode_next  = mode_reg;
        frac_next  = frac_reg;
        sq_next    = sq_reg;
        esc_next   = esc_reg;
        begin_next = begin_reg;
        pos_next   = pos_reg;
        do_start   = 1'b0;
        do_close   = 1'b0;
        do_after   = 1'b0;
        close_kind = jtl_pkg::KIND_INTEGER;

        case (mode_reg)
            jtl_pkg::MODE_START:
            begin
                do_start = 1'b1;
            end
            jtl_pkg::MODE_STRING:
            begin
                if (esc_reg)
                    esc_next = 1'b0;
                else if (text_byte == jtl_pkg::CH_BSLASH)
                    esc_next = 1'b1;
                else if (text_byte == quote_char)
                begin
                    res       = add_tok(res, jtl_pkg::KIND_STRING, begin_reg, pos_reg);
                    mode_next = jtl_pkg::MODE_AFTER;
                end
            end
            jtl_pkg::MODE_AFTER:
            begin
                do_after = 1'b1;
            end
            jtl_pkg::MODE_ZERO:
            begin
                if (is_digit)
                begin
                    res       = add_tok(res, jtl_pkg::KIND_ERROR, begin_reg, pos_reg);
                    mode_next = jtl_pkg::MODE_HALTED;
                end
                else if (text_byte == jtl_pkg::CH_DOT)
                begin
                    frac_next = 1'b1;
                    mode_next = jtl_pkg::MODE_FRAC;
                end
                else if (is_exp_mark)
                    mode_next = jtl_pkg::MODE_EXP_START;
                else
                    do_close = 1'b1;
            end
            jtl_pkg::MODE_SIGN:
            begin
                if (text_byte == jtl_pkg::CH_ZERO)
                    mode_next = jtl_pkg::MODE_ZERO;
                else if (is_digit)
                    mode_next = jtl_pkg::MODE_INT;
                else
                begin
                    res       = add_tok(res, jtl_pkg::KIND_ERROR, begin_reg, pos_reg);
                    mode_next = jtl_pkg::MODE_HALTED;
                end
            end
            jtl_pkg::MODE_INT:
            begin
                if (is_digit)
                    mode_next = jtl_pkg::MODE_INT;
                else if (text_byte == jtl_pkg::CH_DOT)
                begin
                    frac_next = 1'b1;
                    mode_next = jtl_pkg::MODE_FRAC;
                end
                else if (is_exp_mark)
                    mode_next = jtl_pkg::MODE_EXP_START;
                else
                    do_close = 1'b1;
            end
            jtl_pkg::MODE_FRAC:
            begin
                if (is_exp_mark)
                    mode_next = jtl_pkg::MODE_EXP_START;
                else if (!is_digit)
                begin
                    do_close   = 1'b1;
                    close_kind = jtl_pkg::KIND_FLOAT;
                end
            end
            jtl_pkg::MODE_EXP_START:
            begin
                if (text_byte == jtl_pkg::CH_PLUS || text_byte == jtl_pkg::CH_MINUS)
                    mode_next = jtl_pkg::MODE_EXP_SIGN;
                else if (is_digit)
                    mode_next = jtl_pkg::MODE_EXP_DIGITS;
                else
                begin
                    res       = add_tok(res, jtl_pkg::KIND_ERROR, begin_reg, pos_reg);
                    mode_next = jtl_pkg::MODE_HALTED;
                end
            end
            jtl_pkg::MODE_EXP_SIGN:
            begin
                if (is_digit)
                    mode_next = jtl_pkg::MODE_EXP_DIGITS;
                else
                begin
                    res       = add_tok(res, jtl_pkg::KIND_ERROR, begin_reg, pos_reg);
                    mode_next = jtl_pkg::MODE_HALTED;
                end
            end
            jtl_pkg::MODE_EXP_DIGITS:
            begin
                if (!is_digit)
                begin
                    do_close   = 1'b1;
                    close_kind = frac_reg ? jtl_pkg::KIND_FLOAT : jtl_pkg::KIND_INTEGER;
                end
            end
            jtl_pkg::MODE_KEYWORD:
            begin
                if (!is_alpha)
                begin
                    do_close   = 1'b1;
                    close_kind = jtl_pkg::KIND_KEYWORD;
                end
            end
            default:
            begin
                mode_next = jtl_pkg::MODE_HALTED;
            end
        endcase

        // A number or keyword ends at the previous byte; then this byte is checked.
        if (do_close)
        begin
            res      = add_tok(res, close_kind, begin_reg, pos_reg - POS_ONE);
            do_after = 1'b1;
        end

        // Only a terminator may follow a finished token.
        if (do_after)
        begin
            if (is_term)
                do_start = 1'b1;
            else
            begin
                res       = add_tok(res, jtl_pkg::KIND_ERROR, pos_reg, pos_reg);
                mode_next = jtl_pkg::MODE_HALTED;
            end
        end

        // Byte seen between tokens.
        if (do_start)
        begin
            mode_next = jtl_pkg::MODE_START;
            frac_next = 1'b0;
            esc_next  = 1'b0;
            if (!is_space)
            begin
                if (is_punct)
                    res = add_tok(res, punct_kind, pos_reg, pos_reg);
                else
                begin
                    begin_next = pos_reg;
                    if (text_byte == jtl_pkg::CH_DQUOTE || text_byte == jtl_pkg::CH_SQUOTE)
                    begin
                        sq_next   = (text_byte == jtl_pkg::CH_SQUOTE);
                        mode_next = jtl_pkg::MODE_STRING;
                    end
                    else if (text_byte == jtl_pkg::CH_ZERO)
                        mode_next = jtl_pkg::MODE_ZERO;
                    else if (is_digit)
                        mode_next = jtl_pkg::MODE_INT;
                    else if (text_byte == jtl_pkg::CH_MINUS)
                        mode_next = jtl_pkg::MODE_SIGN;
                    else if (is_lower)
                        mode_next = jtl_pkg::MODE_KEYWORD;
                    else
                    begin
                        res       = add_tok(res, jtl_pkg::KIND_ERROR, pos_reg, pos_reg);
                        mode_next = jtl_pkg::MODE_HALTED;
                    end
                end
            end
        end

        // End of text flushes a pending token and returns to the reset state.
        if (end_of_text)
        begin
            if (mode_next inside {jtl_pkg::MODE_ZERO, jtl_pkg::MODE_INT,
                                  jtl_pkg::MODE_FRAC, jtl_pkg::MODE_EXP_DIGITS})
                res = add_tok(res, frac_next ? jtl_pkg::KIND_FLOAT : jtl_pkg::KIND_INTEGER,
                              begin_next, pos_reg);
            else if (mode_next == jtl_pkg::MODE_KEYWORD)
                res = add_tok(res, jtl_pkg::KIND_KEYWORD, begin_next, pos_reg);
            else if (mode_next inside {jtl_pkg::MODE_STRING, jtl_pkg::MODE_SIGN,
                                       jtl_pkg::MODE_EXP_START, jtl_pkg::MODE_EXP_SIGN})
                res = add_tok(res, jtl_pkg::KIND_ERROR, begin_next, pos_reg);
            mode_next  = jtl_pkg::MODE_START;
            frac_next  = 1'b0;
            sq_next    = 1'b0;
            esc_next   = 1'b0;
            begin_next = '0;
            pos_next   = '0;
        end
        else
            pos_next = pos_reg + POS_ONE;

        // Mark the last token of this byte.
        if (res.count == 2'd1)
            res.tok0.last_of_run = 1'b1;
        else if (res.count == 2'd2)
            res.tok1.last_of_run = 1'b1;
    end

    assign results = res;

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= jtl_pkg::MODE_START;
            frac_reg  <= 1'b0;
            sq_reg    <= 1'b0;
            esc_reg   <= 1'b0;
            begin_reg <= '0;
            pos_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            frac_reg  <= frac_next;
            sq_reg    <= sq_next;
            esc_reg   <= esc_next;
            begin_reg <= begin_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

FILE: rtl/jtl_queue.sv
// Small token queue that takes up to two tokens a cycle and releases one.
`timescale 1ns / 1ps

module jtl_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jtl_pkg::results_t push_data,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output jtl_pkg::token_t   out_token
);

    localparam int AW = jtl_pkg::QUEUE_AW;

    jtl_pkg::token_t       mem [jtl_pkg::QUEUE_DEPTH];
    logic [AW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [AW:0]           count_reg, count_next;
    logic [1:0]            n_push;
    logic                  pop;

    // Room for the two tokens that one byte may cause.
    assign room      = (count_reg <= (AW+1)'(jtl_pkg::QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_token = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        n_push      = push ? push_data.count : 2'd0;
        wr_ptr_next = wr_ptr_reg + AW'(n_push);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + (AW+1)'(n_push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Token storage, written in order at up to two places.
    always_ff @(posedge clk)
    begin
        if (push && push_data.count != 2'd0)
            mem[wr_ptr_reg] <= push_data.tok0;
        if (push && push_data.count == 2'd2)
            mem[wr_ptr_reg + AW'(1)] <= push_data.tok1;
    end

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the JSON token lexer: directed and random text in, tokens checked.
`timescale 1ns / 1ps

module tb;

    localparam int N_ITEMS      = 1900;
    localparam int CALM_ITEMS   = 250;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 20;

    // One text byte as it waits to be sent.
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       pause;
    } text_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    text_item_t       text_items[$];
    logic [7:0]       text_buf[$];
    jtl_pkg::token_t  awaited_tokens[$];
    text_item_t       next_item;
    jtl_pkg::token_t  head_token;
    logic             pause_next = 1'b0;
    logic             calm = 1'b0;
    int               send_gap = 0;
    int               recv_stall = 0;
    int               idle_cycles = 0;
    int               mismatches = 0;

    // Lexer state as the checker tracks it.
    jtl_pkg::mode_t   lx_mode = jtl_pkg::MODE_START;
    logic             lx_frac = 1'b0;
    logic             lx_squote = 1'b0;
    logic             lx_escape = 1'b0;
    logic [31:0]      lx_begin = '0;
    logic [31:0]      lx_pos = '0;
    jtl_pkg::token_t  step_toks[2];
    int               step_cnt;

    json_token_lexer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic is_digit(logic [7:0] c);
        return c >= jtl_pkg::CH_ZERO && c <= jtl_pkg::CH_NINE;
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= jtl_pkg::CH_LOW_A && c <= jtl_pkg::CH_LOW_Z)
            || (c >= jtl_pkg::CH_UP_A && c <= jtl_pkg::CH_UP_Z);
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == jtl_pkg::CH_SPACE || c == jtl_pkg::CH_TAB || c == jtl_pkg::CH_CR
            || c == jtl_pkg::CH_LF;
    endfunction

    // Records one token of the current byte; a byte yields at most two.
    function automatic void note_token(jtl_pkg::kind_t k, logic [31:0] f, logic [31:0] l);
        if (step_cnt < 2)
        begin
            step_toks[step_cnt] = '{kind: k, first_pos: f, final_pos: l, last_of_run: 1'b0};
            step_cnt++;
        end
    endfunction

    function automatic void lx_fail(logic [31:0] f, logic [31:0] p);
        note_token(jtl_pkg::KIND_ERROR, f, p);
        lx_mode = jtl_pkg::MODE_HALTED;
    endfunction

    // Handles a byte seen between tokens.
    function automatic void lx_start(logic [7:0] c, logic [31:0] p);
        lx_mode = jtl_pkg::MODE_START;
        lx_frac = 1'b0;
        lx_escape = 1'b0;
        if (is_blank(c))
            return;
        case (c)
            jtl_pkg::CH_LCURLY:  note_token(jtl_pkg::KIND_LCURLY, p, p);
            jtl_pkg::CH_RCURLY:  note_token(jtl_pkg::KIND_RCURLY, p, p);
            jtl_pkg::CH_LSQUARE: note_token(jtl_pkg::KIND_LSQUARE, p, p);
            jtl_pkg::CH_RSQUARE: note_token(jtl_pkg::KIND_RSQUARE, p, p);
            jtl_pkg::CH_COLON:   note_token(jtl_pkg::KIND_COLON, p, p);
            jtl_pkg::CH_COMMA:   note_token(jtl_pkg::KIND_COMMA, p, p);
            default:
            begin
                lx_begin = p;
                if (c == jtl_pkg::CH_DQUOTE || c == jtl_pkg::CH_SQUOTE)
                begin
                    lx_squote = (c == jtl_pkg::CH_SQUOTE);
                    lx_mode = jtl_pkg::MODE_STRING;
                end
                else if (c == jtl_pkg::CH_ZERO)
                    lx_mode = jtl_pkg::MODE_ZERO;
                else if (is_digit(c))
                    lx_mode = jtl_pkg::MODE_INT;
                else if (c == jtl_pkg::CH_MINUS)
                    lx_mode = jtl_pkg::MODE_SIGN;
                else if (c >= jtl_pkg::CH_LOW_A && c <= jtl_pkg::CH_LOW_Z)
                    lx_mode = jtl_pkg::MODE_KEYWORD;
                else
                    lx_fail(p, p);
            end
        endcase
    endfunction

    // Only a closing bracket, a separator or a blank may follow a finished token.
    function automatic void lx_after(logic [7:0] c, logic [31:0] p);
        if (is_blank(c) || c == jtl_pkg::CH_RCURLY || c == jtl_pkg::CH_RSQUARE
                || c == jtl_pkg::CH_COMMA || c == jtl_pkg::CH_COLON)
            lx_start(c, p);
        else
            lx_fail(p, p);
    endfunction

    function automatic void lx_close(jtl_pkg::kind_t k, logic [7:0] c, logic [31:0] p);
        note_token(k, lx_begin, p - 32'd1);
        lx_after(c, p);
    endfunction

    function automatic jtl_pkg::kind_t number_kind();
        return lx_frac ? jtl_pkg::KIND_FLOAT : jtl_pkg::KIND_INTEGER;
    endfunction

    // Works out the tokens that one accepted byte causes and queues them.
    function automatic void lex_byte(logic [7:0] c, logic eot);
        logic [31:0] p;
        logic [7:0]  quote;
        p = lx_pos;
        quote = lx_squote ? jtl_pkg::CH_SQUOTE : jtl_pkg::CH_DQUOTE;
        step_cnt = 0;
        case (lx_mode)
            jtl_pkg::MODE_START: lx_start(c, p);
            jtl_pkg::MODE_STRING:
            begin
                if (lx_escape)
                    lx_escape = 1'b0;
                else if (c == jtl_pkg::CH_BSLASH)
                    lx_escape = 1'b1;
                else if (c == quote)
                begin
                    note_token(jtl_pkg::KIND_STRING, lx_begin, p);
                    lx_mode = jtl_pkg::MODE_AFTER;
                end
            end
            jtl_pkg::MODE_AFTER: lx_after(c, p);
            jtl_pkg::MODE_ZERO:
            begin
                if (is_digit(c))
                    lx_fail(lx_begin, p);
                else if (c == jtl_pkg::CH_DOT)
                begin
                    lx_frac = 1'b1;
                    lx_mode = jtl_pkg::MODE_FRAC;
                end
                else if (c == jtl_pkg::CH_LOW_E || c == jtl_pkg::CH_UP_E)
                    lx_mode = jtl_pkg::MODE_EXP_START;
                else
                    lx_close(jtl_pkg::KIND_INTEGER, c, p);
            end
            jtl_pkg::MODE_SIGN:
            begin
                if (c == jtl_pkg::CH_ZERO)
                    lx_mode = jtl_pkg::MODE_ZERO;
                else if (is_digit(c))
                    lx_mode = jtl_pkg::MODE_INT;
                else
                    lx_fail(lx_begin, p);
            end
            jtl_pkg::MODE_INT:
            begin
                if (is_digit(c))
                    ;
                else if (c == jtl_pkg::CH_DOT)
                begin
                    lx_frac = 1'b1;
                    lx_mode = jtl_pkg::MODE_FRAC;
                end
                else if (c == jtl_pkg::CH_LOW_E || c == jtl_pkg::CH_UP_E)
                    lx_mode = jtl_pkg::MODE_EXP_START;
                else
                    lx_close(jtl_pkg::KIND_INTEGER, c, p);
            end
            jtl_pkg::MODE_FRAC:
            begin
                if (is_digit(c))
                    ;
                else if (c == jtl_pkg::CH_LOW_E || c == jtl_pkg::CH_UP_E)
                    lx_mode = jtl_pkg::MODE_EXP_START;
                else
                    lx_close(jtl_pkg::KIND_FLOAT, c, p);
            end
            jtl_pkg::MODE_EXP_START:
            begin
                if (c == jtl_pkg::CH_PLUS || c == jtl_pkg::CH_MINUS)
                    lx_mode = jtl_pkg::MODE_EXP_SIGN;
                else if (is_digit(c))
                    lx_mode = jtl_pkg::MODE_EXP_DIGITS;
                else
                    lx_fail(lx_begin, p);
            end
            jtl_pkg::MODE_EXP_SIGN:
            begin
                if (is_digit(c))
                    lx_mode = jtl_pkg::MODE_EXP_DIGITS;
                else
                    lx_fail(lx_begin, p);
            end
            jtl_pkg::MODE_EXP_DIGITS:
            begin
                if (!is_digit(c))
                    lx_close(number_kind(), c, p);
            end
            jtl_pkg::MODE_KEYWORD:
            begin
                if (!is_letter(c))
                    lx_close(jtl_pkg::KIND_KEYWORD, c, p);
            end
            default: lx_mode = jtl_pkg::MODE_HALTED;
        endcase

        // End of text flushes a pending token and returns to the reset state.
        if (eot)
        begin
            case (lx_mode)
                jtl_pkg::MODE_ZERO, jtl_pkg::MODE_INT, jtl_pkg::MODE_FRAC,
                jtl_pkg::MODE_EXP_DIGITS:
                    note_token(number_kind(), lx_begin, p);
                jtl_pkg::MODE_KEYWORD:
                    note_token(jtl_pkg::KIND_KEYWORD, lx_begin, p);
                jtl_pkg::MODE_STRING, jtl_pkg::MODE_SIGN, jtl_pkg::MODE_EXP_START,
                jtl_pkg::MODE_EXP_SIGN:
                    note_token(jtl_pkg::KIND_ERROR, lx_begin, p);
                default: ;
            endcase
            lx_mode = jtl_pkg::MODE_START;
            lx_frac = 1'b0;
            lx_squote = 1'b0;
            lx_escape = 1'b0;
            lx_begin = '0;
            lx_pos = '0;
        end
        else
            lx_pos = p + 32'd1;

        if (step_cnt > 0)
            step_toks[step_cnt - 1].last_of_run = 1'b1;
        for (int i = 0; i < step_cnt; i++)
            awaited_tokens.push_back(step_toks[i]);
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // Text generation: bytes collect in text_buf and then become items.
    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endfunction

    function automatic void put_pick(string s);
        text_buf.push_back(s[$urandom_range(0, s.len() - 1)]);
    endfunction

    function automatic void put_digit(logic [7:0] low);
        text_buf.push_back(8'($urandom_range(low, jtl_pkg::CH_NINE)));
    endfunction

    function automatic void queue_text();
        text_item_t it;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            it.ch = text_buf[i];
            it.eot = (i == text_buf.size() - 1);
            it.pause = (i == 0) && pause_next;
            text_items.push_back(it);
        end
        pause_next = 1'b0;
        text_buf.delete();
    endfunction

    function automatic void gen_number();
        if ($urandom_range(0, 3) == 0)
            text_buf.push_back(jtl_pkg::CH_MINUS);
        // Now and then no digits follow: a lone sign, or no number at all.
        if ($urandom_range(0, 19) == 0)
            return;
        if ($urandom_range(0, 3) == 0)
        begin
            text_buf.push_back(jtl_pkg::CH_ZERO);
            if ($urandom_range(0, 9) == 0)
                put_digit(jtl_pkg::CH_ZERO);
        end
        else
        begin
            put_digit(jtl_pkg::CH_ZERO + 8'd1);
            repeat ($urandom_range(0, 4))
                put_digit(jtl_pkg::CH_ZERO);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            text_buf.push_back(jtl_pkg::CH_DOT);
            repeat ($urandom_range(0, 3))
                put_digit(jtl_pkg::CH_ZERO);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            put_pick("eE");
            if ($urandom_range(0, 1) == 0)
                put_pick("+-");
            // Mostly at least one exponent digit, sometimes none.
            repeat (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3))
                put_digit(jtl_pkg::CH_ZERO);
        end
    endfunction

    function automatic void gen_string();
        logic [7:0] quote;
        logic [7:0] c;
        quote = $urandom_range(0, 1) ? jtl_pkg::CH_SQUOTE : jtl_pkg::CH_DQUOTE;
        text_buf.push_back(quote);
        repeat ($urandom_range(0, 8))
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                text_buf.push_back(jtl_pkg::CH_BSLASH);
                text_buf.push_back(8'($urandom_range(0, 255)));
            end
            else if ($urandom_range(0, 9) == 0)
                text_buf.push_back(8'($urandom_range(128, 255)));
            else
            begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                if (c == quote || c == jtl_pkg::CH_BSLASH)
                    c = jtl_pkg::CH_SPACE;
                text_buf.push_back(c);
            end
        end
        text_buf.push_back(quote);
    endfunction

    function automatic void gen_keyword();
        text_buf.push_back(8'($urandom_range(jtl_pkg::CH_LOW_A, jtl_pkg::CH_LOW_Z)));
        repeat ($urandom_range(0, 6))
        begin
            if ($urandom_range(0, 1))
                text_buf.push_back(8'($urandom_range(jtl_pkg::CH_LOW_A, jtl_pkg::CH_LOW_Z)));
            else
                text_buf.push_back(8'($urandom_range(jtl_pkg::CH_UP_A, jtl_pkg::CH_UP_Z)));
        end
    endfunction

    // A sequence of tokens, mostly well-formed; the text may end without a terminator.
    function automatic void gen_doc();
        int n;
        int pick;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 2)
            begin
                put_pick("{}[]:,");
                if ($urandom_range(0, 1))
                    put_pick(" \t\r\n");
            end
            else
            begin
                if (pick <= 5)
                    gen_number();
                else if (pick <= 7)
                    gen_string();
                else
                    gen_keyword();
                if (i < n - 1 || $urandom_range(0, 1))
                begin
                    put_pick(" \t\r\n,:}]");
                    if ($urandom_range(0, 3) == 0)
                        put_pick(" \t\r\n");
                end
            end
        end
    endfunction

    // Byte sender.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tlast <= 1'b0;
            send_gap <= 0;
            calm <= 1'b0;
        end
        else
        begin
            // A byte taken at this edge: work out the tokens it causes.
            if (s_tvalid && s_tready)
                lex_byte(s_tdata, s_tlast);
            calm <= (text_items.size() < CALM_ITEMS);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (text_items.size() == 0)
                    s_tvalid <= 1'b0;
                else if (text_items[0].pause && awaited_tokens.size() != 0)
                    s_tvalid <= 1'b0;
                else if (!calm && $urandom_range(0, 15) == 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= $urandom_range(0, 12);
                end
                else
                begin
                    next_item = text_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_item.ch;
                    s_tlast <= next_item.eot;
                end
            end
        end
    end

    // Token receiver and checker.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_tokens.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no token, got kind %0d span %0d..%0d",
                             $time, m_tuser, m_tdata[31:0], m_tdata[63:32]);
                end
                else
                begin
                    head_token = awaited_tokens.pop_front();
                    check_field("token_kind", 32'(head_token.kind), 32'(m_tuser));
                    check_field("first_pos", head_token.first_pos, m_tdata[31:0]);
                    check_field("final_pos", head_token.final_pos, m_tdata[63:32]);
                    check_field("last_of_run", 32'(head_token.last_of_run), 32'(m_tlast));
                end
            end
            if (recv_stall != 0)
            begin
                recv_stall <= recv_stall - 1;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 15) == 0)
            begin
                m_tready <= 1'b0;
                recv_stall <= $urandom_range(0, 12);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Ends the run when neither side moves an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles == IDLE_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int roll;
        logic paused_mid;
        paused_mid = 1'b0;

        // Directed texts: punctuation, escapes, number forms, errors and flushes.
        put_str("{\"x\\\"\":-0.e+7,t}");
        queue_text();
        // Opening bracket right after a string.
        put_str("'q'[");
        queue_text();
        // Digit after a leading zero.
        put_str("01");
        queue_text();
        text_buf.push_back(8'hFF);
        queue_text();
        // Pending integer, then an unfinished exponent, flushed at end of text.
        put_str("7");
        queue_text();
        put_str("1e");
        queue_text();

        // Random texts, mostly well-formed, some corrupted, some noise.
        pause_next = 1'b1;
        while (text_items.size() < N_ITEMS)
        begin
            if (!paused_mid && text_items.size() > N_ITEMS / 2)
            begin
                pause_next = 1'b1;
                paused_mid = 1'b1;
            end
            roll = $urandom_range(0, 9);
            if (roll == 0)
            begin
                repeat ($urandom_range(1, 8))
                    text_buf.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                gen_doc();
                if (roll <= 2)
                    text_buf[$urandom_range(0, text_buf.size() - 1)] =
                        8'($urandom_range(0, 255));
            end
            queue_text();
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (text_items.size() != 0 || s_tvalid || awaited_tokens.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && awaited_tokens.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
